FILE: hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hdl/mrbt_pkg.sv
package mrbt_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  localparam logic [1:0] VERDICT_REJECT    = 2'd0;
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
  localparam logic [1:0] VERDICT_PROBABLE  = 2'd2;
  localparam logic [1:0] VERDICT_TWO       = 2'd3;

  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATE_W-1:0] ST_STRIP  = 3'd1;
  localparam logic [STATE_W-1:0] ST_REDUCE = 3'd2;
  localparam logic [STATE_W-1:0] ST_PSQ    = 3'd3;
  localparam logic [STATE_W-1:0] ST_PMUL   = 3'd4;
  localparam logic [STATE_W-1:0] ST_SQL    = 3'd5;
  localparam logic [STATE_W-1:0] ST_SQW    = 3'd6;
  localparam logic [STATE_W-1:0] ST_FIN    = 3'd7;

endpackage

FILE: hdl/mrbt_modmul.sv
`include "assert_macros.svh"

module mrbt_modmul #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          x,
  input  logic [W-1:0]          y,
  input  logic [W-1:0]          n,
  output logic [W-1:0]          result,
  output mrbt_pkg::mm_stat_t    stat
);
  import mrbt_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc, xr, yr, nr;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dbl, acc_next;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] p, input logic [W-1:0] q,
                                           input logic [W-1:0] m);
    logic [W-1:0] room;
    room = m - q;
    return (p >= room) ? (p - room) : (p + q);
  endfunction

  always_comb begin
    dbl      = add_mod(acc, acc, nr);
    acc_next = yr[W-1] ? add_mod(dbl, xr, nr) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && cnt == CW'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      nr  <= n;
      cnt <= CW'(W);
    end else if (stat.busy) begin
      acc <= acc_next;
      yr  <= yr << 1;
      cnt <= cnt - CW'(1);
    end
  end

  assign result = acc;

  `ASSERT_NEVER(a_start_busy, clk, rst, start && stat.busy, "start while busy")
  `ASSERT_NEVER(a_done_busy, clk, rst, stat.done && stat.busy, "done while busy")
  `ASSERT_CLK(a_res_lt_n, clk, rst, stat.done |-> (acc < nr), "result not reduced")

endmodule

FILE: hdl/miller_rabin_base_test.sv
// Miller-Rabin single-base test, one shared shift-and-add modular multiplier.
// Even candidates and those below 3 go straight to the verdict; for odd ones base^d mod n
//   is computed by square-and-multiply, and when the power is not one, up to b squarings follow.
// s_tready only while idle: one item at a time, and a pending verdict stalls the next.
// Reset (rst, synchronous) returns the sequencer to idle and drops m_tvalid.
module miller_rabin_base_test #(
  parameter int NUM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // [31:0] candidate, [63:32] test_base
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // [1:0] verdict, rest zero
);
  import mrbt_pkg::*;

  localparam int W  = NUM_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [STATE_W-1:0] state;
  logic [W-1:0]       n, a, d, base, r, e;
  logic [CW-1:0]      b, ecnt, icnt;
  logic [1:0]         verdict;
  logic               mm_start;
  logic [W-1:0]       mm_x, mm_y, mm_res;
  mm_stat_t           mm_stat;
  logic [W-1:0]       cand, tb;
  logic               fin_fire, mm_wait;

  assign cand = W'(s_tdata[31:0]);
  assign tb   = W'(s_tdata[63:32]);
  assign s_tready = (state == ST_IDLE);
  assign fin_fire = (state == ST_FIN) && (!m_tvalid || m_tready);
  assign mm_wait  = (state == ST_REDUCE) || (state == ST_PSQ) || (state == ST_PMUL) ||
                    (state == ST_SQW);

  mrbt_modmul #(.W(W)) u_mm (
    .clk(clk), .rst(rst), .start(mm_start), .x(mm_x), .y(mm_y), .n(n),
    .result(mm_res), .stat(mm_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mm_start <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            n <= cand;
            a <= tb;
            d <= cand - W'(1);
            b <= '0;
            if (cand == W'(2)) begin
              verdict <= VERDICT_TWO;
              state   <= ST_FIN;
            end else if (!cand[0] || cand < W'(2)) begin
              verdict <= VERDICT_REJECT;
              state   <= ST_FIN;
            end else begin
              state <= ST_STRIP;
            end
          end
        end
        ST_STRIP: begin
          if (!d[0]) begin
            d <= d >> 1;
            b <= b + CW'(1);
          end else begin
            mm_x     <= W'(1);
            mm_y     <= a;
            mm_start <= 1'b1;
            state    <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mm_stat.done) begin
            base     <= mm_res;
            e        <= d;
            ecnt     <= CW'(W);
            mm_x     <= W'(1);
            mm_y     <= W'(1);
            mm_start <= 1'b1;
            state    <= ST_PSQ;
          end
        end
        ST_PSQ, ST_PMUL: begin
          if (mm_stat.done) begin
            r <= mm_res;
            if (state == ST_PSQ && e[W-1]) begin
              mm_x     <= mm_res;
              mm_y     <= base;
              mm_start <= 1'b1;
              state    <= ST_PMUL;
            end else if (ecnt == CW'(1)) begin
              icnt <= b;
              if (mm_res == W'(1)) begin
                verdict <= VERDICT_PROBABLE;
                state   <= ST_FIN;
              end else begin
                state <= ST_SQL;
              end
            end else begin
              e        <= e << 1;
              ecnt     <= ecnt - CW'(1);
              mm_x     <= mm_res;
              mm_y     <= mm_res;
              mm_start <= 1'b1;
              state    <= ST_PSQ;
            end
          end
        end
        ST_SQL: begin
          if (icnt == '0) begin
            verdict <= VERDICT_COMPOSITE;
            state   <= ST_FIN;
          end else if (r == n - W'(1)) begin
            verdict <= VERDICT_PROBABLE;
            state   <= ST_FIN;
          end else begin
            icnt     <= icnt - CW'(1);
            mm_x     <= r;
            mm_y     <= r;
            mm_start <= 1'b1;
            state    <= ST_SQW;
          end
        end
        ST_SQW: begin
          if (mm_stat.done) begin
            r     <= mm_res;
            state <= ST_SQL;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            m_tdata <= {6'd0, verdict};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_fin_idle, clk, rst, fin_fire |=> (m_tvalid && state == ST_IDLE), "result not issued")
  `ASSERT_NEVER(a_done_wait, clk, rst, mm_stat.done && !mm_wait, "product lost")
  `ASSERT_NEVER(a_start_idle, clk, rst, mm_start && (state == ST_IDLE || state == ST_FIN), "start outside computation")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mrbt_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  miller_rabin_base_test u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #2 clk = ~clk;

  logic [1:0] verdict_q[$];
  int         n_errors = 0;
  int         n_verdicts = 0;
  int         n_items = 0;
  int         idle_cycles = 0;
  bit         no_idle = 1'b0;
  int         verdict_hist[4];

  // exact (x*y) mod n, x,y < n
  function automatic logic [31:0] mulmod(logic [31:0] x, logic [31:0] y, logic [31:0] n);
    logic [63:0] p;
    p = {32'd0, x} * {32'd0, y};
    return 32'(p % {32'd0, n});
  endfunction

  function automatic logic [1:0] witness_verdict(logic [31:0] n, logic [31:0] a);
    logic [31:0] d;
    logic [31:0] x;
    logic [31:0] bse;
    int          b;
    if (n == 32'd2) return VERDICT_TWO;
    if (!n[0] || n <= 32'd1) return VERDICT_REJECT;
    d = n - 32'd1;
    b = 0;
    while (!d[0]) begin
      d = d >> 1;
      b++;
    end
    bse = a % n;
    x = 32'd1;
    for (int i = 31; i >= 0; i--) begin
      x = mulmod(x, x, n);
      if (d[i]) x = mulmod(x, bse, n);
    end
    if (x == 32'd1) return VERDICT_PROBABLE;
    for (int i = 0; i < b; i++) begin
      if (x == n - 32'd1) return VERDICT_PROBABLE;
      x = mulmod(x, x, n);
    end
    return VERDICT_COMPOSITE;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 19);
  endfunction

  // directed rows: candidate, base, expected (known) or predicted
  typedef struct {
    logic [31:0] cand;
    logic [31:0] base;
    bit          known;
    logic [1:0]  verdict;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{32'd0,          32'd5,          1'b1, VERDICT_REJECT},
    '{32'd1,          32'd0,          1'b1, VERDICT_REJECT},
    '{32'd2,          32'hFFFF_FFFF,  1'b1, VERDICT_TWO},
    '{32'd4,          32'd3,          1'b1, VERDICT_REJECT},
    '{32'hFFFF_FFFE,  32'd2,          1'b1, VERDICT_REJECT},
    '{32'd3,          32'd2,          1'b1, VERDICT_PROBABLE},
    '{32'd9,          32'd9,          1'b1, VERDICT_COMPOSITE},
    '{32'd9,          32'd0,          1'b1, VERDICT_COMPOSITE},
    '{32'd9,          32'd1,          1'b1, VERDICT_PROBABLE},
    '{32'd9,          32'd8,          1'b1, VERDICT_PROBABLE},
    '{32'd9,          32'd2,          1'b0, 2'd0},
    '{32'd561,        32'd2,          1'b0, 2'd0},
    '{32'd2047,       32'd2,          1'b0, 2'd0},
    '{32'd97,         32'd1000,       1'b0, 2'd0},
    '{32'hFFFF_FFFB,  32'hFFFF_FFFF,  1'b0, 2'd0},
    '{32'hFFFF_FFFB,  32'd2,          1'b0, 2'd0},
    '{32'hFFFF_FFFF,  32'h8000_0000,  1'b0, 2'd0},
    '{32'h8000_0001,  32'hAAAA_5555,  1'b0, 2'd0},
    '{32'd65537,      32'hFFFF_FFFF,  1'b0, 2'd0},
    '{32'd4294967291, 32'd4294967290, 1'b1, VERDICT_PROBABLE}
  };

  task automatic send_item(logic [31:0] cand, logic [31:0] base, logic [1:0] verdict);
    while (idle_now()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= {base, cand};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdict_q.push_back(verdict);
    n_items++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_odd_cand();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom_range(3, 255);
      1: v = $urandom_range(3, 65535);
      2: v = $urandom;
      default: v = 32'hFFFF_FFFF - $urandom_range(200);
    endcase
    return v;
  endfunction

  always @(negedge clk) m_tready <= !idle_now();

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_verdicts++;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict beat, actual %0d", $time, m_tdata[1:0]);
        n_errors++;
      end else begin
        logic [1:0] want;
        want = verdict_q.pop_front();
        verdict_hist[want]++;
        if (m_tdata != {6'd0, want}) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, want, m_tdata);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] cand;
    logic [31:0] base;
    logic [1:0]  want;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      want = dir_rows[i].known ? dir_rows[i].verdict
                               : witness_verdict(dir_rows[i].cand, dir_rows[i].base);
      send_item(dir_rows[i].cand, dir_rows[i].base, want);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 60 && i < 90);
      if ($urandom_range(9) < 8) begin
        cand = rand_odd_cand() | 32'd1;
        base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2, 200);
      end else begin
        cand = $urandom;
        base = $urandom;
      end
      send_item(cand, base, witness_verdict(cand, base));
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d items, checked %0d verdicts", n_items, n_verdicts);
    $display("reject %0d, composite %0d, probable %0d, two %0d",
             verdict_hist[0], verdict_hist[1], verdict_hist[2], verdict_hist[3]);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: miller_rabin_base_test.f
+incdir+hdl
hdl/mrbt_pkg.sv
hdl/mrbt_modmul.sv
hdl/miller_rabin_base_test.sv
verif/testbench.sv
